### rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the banker's safety check
// Command codes, register indexes, stream field layout, sequencer states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // stream field widths
    localparam int CMD_BITS      = 2;
    localparam int PIDX_BITS     = 3;
    localparam int RIDX_BITS     = 2;
    localparam int AMT_IN_BITS   = 8;
    localparam int PID_OUT_BITS  = 3;

    // slave tdata layout
    localparam int LD_PIDX_LSB   = 0;
    localparam int LD_RIDX_LSB   = LD_PIDX_LSB + PIDX_BITS;
    localparam int LD_AMT_LSB    = LD_RIDX_LSB + RIDX_BITS;
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 8;

    // configuration port
    localparam int CFG_DATA_BITS = 4;
    localparam int PROC_CFG_BITS = 4;
    localparam int RES_CFG_BITS  = 3;
    localparam logic [PROC_CFG_BITS-1:0] PROC_CFG_RESET = 4'd8;
    localparam logic [RES_CFG_BITS-1:0]  RES_CFG_RESET  = 3'd4;

    // work vector
    localparam int WORK_BITS = 16;
    localparam logic [WORK_BITS-1:0] WORK_MAX = 16'hFFFF;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD_AVAIL = 2'd0,
        CMD_LOAD_CLAIM = 2'd1,
        CMD_LOAD_ALLOC = 2'd2,
        CMD_RUN        = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_PROCESSES = 1'b0,
        CFG_RESOURCES = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_PROC,
        S_RD_CHK,
        S_CMP,
        S_RD_ADD,
        S_ADD,
        S_EMIT,
        S_UNSAFE
    } t_state;

    typedef struct packed {
        logic load_avail;
        logic load_claim;
        logic load_alloc;
        logic init;
        logic mem_rd;
        logic work_add;
        logic set_done;
        logic emit_safe;
        logic emit_unsafe;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic need_ok;
        logic done_p;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl: sequencer for the safety check
// Holds the configuration registers, the process, resource and sequence
// counters, and walks the passes over processes and resources.
// ----------------------------------------------------------------------------
module bsc_ctrl #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bsc_pkg::t_cmd                       i_in_cmd,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  bsc_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  bsc_pkg::t_dp_stat                   i_stat,
    output bsc_pkg::t_dp_cmd                    o_cmd,
    output logic [PW-1:0]                       o_p,
    output logic [RW-1:0]                       o_r
);
    import bsc_pkg::*;

    localparam int NPW = $clog2(MAX_PROCESSES + 1);
    localparam int NRW = $clog2(MAX_RESOURCES + 1);

    t_state                   r_state, n_state;
    logic [PROC_CFG_BITS-1:0] r_proc_cfg;
    logic [RES_CFG_BITS-1:0]  r_res_cfg;
    logic [PW-1:0]            r_p;
    logic [RW-1:0]            r_r;
    logic [NPW-1:0]           r_cnt;
    logic                     r_found;

    logic [NPW-1:0] w_np;
    logic [NRW-1:0] w_nr;
    logic           w_last_p;
    logic           w_last_r;
    logic           w_last_emit;
    logic           w_accept;
    t_state         w_adv_state;
    logic           w_p_clr, w_advance, w_r_clr, w_r_inc;
    logic           w_run_clr, w_found_set, w_cnt_inc;

    // zero counts as one, larger values saturate
    always_comb begin
        if (r_proc_cfg == '0) begin
            w_np = NPW'(1);
        end else if (int'(r_proc_cfg) > MAX_PROCESSES) begin
            w_np = NPW'(MAX_PROCESSES);
        end else begin
            w_np = NPW'(r_proc_cfg);
        end
        if (r_res_cfg == '0) begin
            w_nr = NRW'(1);
        end else if (int'(r_res_cfg) > MAX_RESOURCES) begin
            w_nr = NRW'(MAX_RESOURCES);
        end else begin
            w_nr = NRW'(r_res_cfg);
        end
    end

    assign w_last_p    = (r_p == PW'(w_np - 1'b1));
    assign w_last_r    = (r_r == RW'(w_nr - 1'b1));
    assign w_last_emit = ((r_cnt + 1'b1) == w_np);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_adv_state = (w_last_p && !r_found) ? S_UNSAFE : S_PROC;
    assign o_p         = r_p;
    assign o_r         = r_r;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_cmd == CMD_RUN)) n_state = S_INIT;
            end
            S_INIT:   n_state = S_PROC;
            S_PROC: begin
                n_state = i_stat.done_p ? w_adv_state : S_RD_CHK;
            end
            S_RD_CHK: n_state = S_CMP;
            S_CMP: begin
                if (!i_stat.need_ok) begin
                    n_state = w_adv_state;
                end else if (w_last_r) begin
                    n_state = S_RD_ADD;
                end else begin
                    n_state = S_RD_CHK;
                end
            end
            S_RD_ADD: n_state = S_ADD;
            S_ADD: begin
                n_state = w_last_r ? S_EMIT : S_RD_ADD;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = w_last_emit ? S_IDLE : S_PROC;
            end
            S_UNSAFE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and counter controls
    always_comb begin
        o_cmd       = '0;
        w_p_clr     = 1'b0;
        w_advance   = 1'b0;
        w_r_clr     = 1'b0;
        w_r_inc     = 1'b0;
        w_run_clr   = 1'b0;
        w_found_set = 1'b0;
        w_cnt_inc   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_avail = w_accept && (i_in_cmd == CMD_LOAD_AVAIL);
                o_cmd.load_claim = w_accept && (i_in_cmd == CMD_LOAD_CLAIM);
                o_cmd.load_alloc = w_accept && (i_in_cmd == CMD_LOAD_ALLOC);
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                w_p_clr    = 1'b1;
                w_r_clr    = 1'b1;
                w_run_clr  = 1'b1;
            end
            S_PROC: begin
                if (i_stat.done_p) begin
                    w_advance = 1'b1;
                end else begin
                    w_r_clr = 1'b1;
                end
            end
            S_RD_CHK: o_cmd.mem_rd = 1'b1;
            S_CMP: begin
                if (!i_stat.need_ok) begin
                    w_advance = 1'b1;
                end else if (w_last_r) begin
                    w_r_clr = 1'b1;
                end else begin
                    w_r_inc = 1'b1;
                end
            end
            S_RD_ADD: o_cmd.mem_rd = 1'b1;
            S_ADD: begin
                o_cmd.work_add = 1'b1;
                if (w_last_r) begin
                    w_r_clr = 1'b1;
                end else begin
                    w_r_inc = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_safe = 1'b1;
                    o_cmd.set_done  = 1'b1;
                    o_cmd.last      = w_last_emit;
                    w_cnt_inc       = 1'b1;
                    w_found_set     = 1'b1;
                    w_advance       = 1'b1;
                end
            end
            S_UNSAFE: begin
                o_cmd.emit_unsafe = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_proc_cfg <= PROC_CFG_RESET;
            r_res_cfg  <= RES_CFG_RESET;
            r_p        <= '0;
            r_r        <= '0;
            r_cnt      <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PROCESSES: r_proc_cfg <= i_cfg_data;
                    CFG_RESOURCES: r_res_cfg  <= i_cfg_data[RES_CFG_BITS-1:0];
                    default:       r_proc_cfg <= r_proc_cfg;
                endcase
            end
            if (w_p_clr) begin
                r_p <= '0;
            end else if (w_advance) begin
                r_p <= w_last_p ? '0 : r_p + 1'b1;
            end
            if (w_r_clr) begin
                r_r <= '0;
            end else if (w_r_inc) begin
                r_r <= r_r + 1'b1;
            end
            if (w_run_clr) begin
                r_cnt <= '0;
            end else if (w_cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            // a wrap to the first process opens a new pass
            if (w_run_clr || (w_advance && w_last_p)) begin
                r_found <= 1'b0;
            end else if (w_found_set) begin
                r_found <= 1'b1;
            end
        end
    end

    a_cnt_below_np: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_INIT) |-> (r_cnt < w_np))
        else $error("sequence count reached process count inside a run");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD_CHK))
        else $error("compare without a preceding store read");

    a_add_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_RD_ADD))
        else $error("work update without a preceding store read");

endmodule

### rtl/bsc_dp.sv
// ----------------------------------------------------------------------------
// bsc_dp: datapath for the safety check
// Available, claim and allocation stores, work vector, finished flags,
// need compare, saturating release and the result register.
// ----------------------------------------------------------------------------
module bsc_dp #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8,
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bsc_pkg::t_dp_cmd                   i_cmd,
    input  logic [PW-1:0]                      i_p,
    input  logic [RW-1:0]                      i_r,
    input  logic [bsc_pkg::PIDX_BITS-1:0]      i_ld_pidx,
    input  logic [bsc_pkg::RIDX_BITS-1:0]      i_ld_ridx,
    input  logic [bsc_pkg::AMT_IN_BITS-1:0]    i_ld_amount,
    output bsc_pkg::t_dp_stat                  o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [bsc_pkg::PID_OUT_BITS-1:0]   o_out_pid,
    output logic                               o_out_safe,
    output logic                               o_out_last
);
    import bsc_pkg::*;

    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AMOUNT_BITS > WORK_BITS) ? AMOUNT_BITS : WORK_BITS;
    localparam int SW    = CW + 1;

    logic [AMOUNT_BITS-1:0]  r_avail [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0]  r_claim_mem [DEPTH];
    logic [AMOUNT_BITS-1:0]  r_alloc_mem [DEPTH];
    logic [AMOUNT_BITS-1:0]  r_claim_q;
    logic [AMOUNT_BITS-1:0]  r_alloc_q;
    logic [WORK_BITS-1:0]    r_work [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_done;
    logic                    r_out_valid;
    logic [PID_OUT_BITS-1:0] r_out_pid;
    logic                    r_out_safe;
    logic                    r_out_last;

    logic [AMOUNT_BITS-1:0] w_amt;
    logic                   w_ridx_ok;
    logic                   w_pidx_ok;
    logic [AW-1:0]          w_wr_addr;
    logic [AW-1:0]          w_rd_addr;
    logic [WORK_BITS-1:0]   w_work_r;
    logic [AMOUNT_BITS-1:0] w_need;
    logic [SW-1:0]          w_sum;
    logic [WORK_BITS-1:0]   w_sum_sat;
    logic                   w_out_free;

    assign w_amt     = AMOUNT_BITS'(i_ld_amount);
    assign w_ridx_ok = (int'(i_ld_ridx) < MAX_RESOURCES);
    assign w_pidx_ok = (int'(i_ld_pidx) < MAX_PROCESSES);
    assign w_wr_addr = AW'(int'(i_ld_pidx) * MAX_RESOURCES + int'(i_ld_ridx));
    assign w_rd_addr = AW'(int'(i_p) * MAX_RESOURCES + int'(i_r));

    assign w_work_r  = r_work[i_r];
    // need clamps at zero when allocation exceeds the claim
    assign w_need    = (r_claim_q > r_alloc_q) ? (r_claim_q - r_alloc_q) : '0;
    assign w_sum     = SW'(w_work_r) + SW'(r_alloc_q);
    assign w_sum_sat = (w_sum > SW'(WORK_MAX)) ? WORK_MAX : WORK_BITS'(w_sum);

    assign w_out_free      = !r_out_valid || i_out_ready;
    assign o_stat.need_ok  = (CW'(w_need) <= CW'(w_work_r));
    assign o_stat.done_p   = r_done[i_p];
    assign o_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_avail && w_ridx_ok) begin
            r_avail[RW'(i_ld_ridx)] <= w_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_claim && w_ridx_ok && w_pidx_ok) begin
            r_claim_mem[w_wr_addr] <= w_amt;
        end
        if (i_cmd.mem_rd) begin
            r_claim_q <= r_claim_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_alloc && w_ridx_ok && w_pidx_ok) begin
            r_alloc_mem[w_wr_addr] <= w_amt;
        end
        if (i_cmd.mem_rd) begin
            r_alloc_q <= r_alloc_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_work[i] <= WORK_BITS'(r_avail[i]);
            end
        end else if (i_cmd.work_add) begin
            r_work[i_r] <= w_sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_done <= '0;
            end else if (i_cmd.set_done) begin
                r_done[i_p] <= 1'b1;
            end
            if (i_cmd.emit_safe || i_cmd.emit_unsafe) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_safe) begin
            r_out_pid  <= PID_OUT_BITS'(i_p);
            r_out_safe <= 1'b1;
            r_out_last <= i_cmd.last;
        end else if (i_cmd.emit_unsafe) begin
            r_out_pid  <= '0;
            r_out_safe <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pid   = r_out_pid;
    assign o_out_safe  = r_out_safe;
    assign o_out_last  = r_out_last;

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_done |-> !r_done[i_p])
        else $error("process finished twice in one run");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_safe || i_cmd.emit_unsafe) |-> w_out_free)
        else $error("result written over an untaken result");

endmodule

### rtl/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check: banker's algorithm safety check
// Loads available, claim and allocation elements, then on a run command
// streams the safe sequence, or an unsafe marker, one result per transfer.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pidx, ridx, amount
//                                               tuser: command
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: process id
//                                               tuser: safe, tlast: last
// cfg       in   i_cfg_valid / o_cfg_ready      index, data
//
// a run holds s_axis_tready low until its last result is in the output
// register. per process visit the sequencer checks the finished flag, then
// per resource compared does a registered store read and a compare, and on a
// fit a store read and a release per resource, then an emit; a run makes up
// to np passes. reset is synchronous and clears control state; stores hold
// garbage until loaded. a full output register stalls the sequencer in its
// emit step.
// ----------------------------------------------------------------------------
module bankers_safety_check #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 4,
    parameter int AMOUNT_BITS   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] process_index, [4:3] resource_index, [12:5] amount
    input  logic [bsc_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
    // [1:0] command
    input  logic [bsc_pkg::CMD_BITS-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] process_id
    output logic [bsc_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,
    // [0] safe
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  bsc_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import bsc_pkg::*;

    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    t_dp_cmd                 w_cmd;
    t_dp_stat                w_stat;
    logic [PW-1:0]           w_p;
    logic [RW-1:0]           w_r;
    logic [PID_OUT_BITS-1:0] w_pid;
    logic                    w_safe;

    bsc_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_cmd    (t_cmd'(s_axis_tuser)),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_p         (w_p),
        .o_r         (w_r)
    );

    bsc_dp #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_p         (w_p),
        .i_r         (w_r),
        .i_ld_pidx   (s_axis_tdata[LD_PIDX_LSB +: PIDX_BITS]),
        .i_ld_ridx   (s_axis_tdata[LD_RIDX_LSB +: RIDX_BITS]),
        .i_ld_amount (s_axis_tdata[LD_AMT_LSB +: AMT_IN_BITS]),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_pid   (w_pid),
        .o_out_safe  (w_safe),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_BITS'(w_pid);
    assign m_axis_tuser = w_safe;

endmodule

### tb/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker: result predictor and scoreboard for the banker's safety check
// Watches the configuration, load/run and result channels. Keeps its own copy
// of the stores and counts, works out the safe sequence for each run command
// and compares every result transfer against the oldest expected entry.
// ----------------------------------------------------------------------------
module bsc_checker
    import bsc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    // [2:0] process_index, [4:3] resource_index, [12:5] amount
    input  logic [S_TDATA_BITS-1:0]    s_axis_tdata,
    // [1:0] command
    input  logic [CMD_BITS-1:0]        s_axis_tuser,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [2:0] process_id
    input  logic [M_TDATA_BITS-1:0]    m_axis_tdata,
    // [0] safe
    input  logic [0:0]                 m_axis_tuser,
    input  logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    input  logic                       o_cfg_ready,
    input  t_cfg_idx                   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 8;
    localparam int NRES  = 4;

    typedef struct packed {
        logic [PID_OUT_BITS-1:0] pid;
        logic                    safe;
        logic                    last;
    } t_seq_entry;

    logic [AMT_IN_BITS-1:0]   avail_mem [NRES];
    logic [AMT_IN_BITS-1:0]   claim_mem [NPROC][NRES];
    logic [AMT_IN_BITS-1:0]   alloc_mem [NPROC][NRES];
    logic [WORK_BITS-1:0]     work_vec  [NRES];
    logic [NPROC-1:0]         done_mask;
    logic [PROC_CFG_BITS-1:0] proc_cnt = PROC_CFG_RESET;
    logic [RES_CFG_BITS-1:0]  res_cnt  = RES_CFG_RESET;

    t_seq_entry safe_seq_q[$];
    int         mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int clamp_cnt(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit need_fits(input int p, input int nr);
        logic [AMT_IN_BITS-1:0] need;
        for (int r = 0; r < nr; r++) begin
            // need never goes negative
            need = (claim_mem[p][r] > alloc_mem[p][r]) ? claim_mem[p][r] - alloc_mem[p][r] : '0;
            if ({{(WORK_BITS-AMT_IN_BITS){1'b0}}, need} > work_vec[r]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic run_safety_check();
        int             np;
        int             nr;
        int             count;
        bit             stuck;
        logic [WORK_BITS:0] sum;
        np    = clamp_cnt(proc_cnt, NPROC);
        nr    = clamp_cnt(res_cnt, NRES);
        for (int r = 0; r < NRES; r++)
            work_vec[r] = (r < nr) ? {{(WORK_BITS-AMT_IN_BITS){1'b0}}, avail_mem[r]} : '0;
        done_mask = '0;
        count     = 0;
        stuck     = 1'b0;
        while (count < np && !stuck) begin
            stuck = 1'b1;
            for (int p = 0; p < np; p++) begin
                if (!done_mask[p] && need_fits(p, nr)) begin
                    for (int r = 0; r < nr; r++) begin
                        sum = work_vec[r] + alloc_mem[p][r];
                        work_vec[r] = sum[WORK_BITS] ? WORK_MAX : sum[WORK_BITS-1:0];
                    end
                    done_mask[p] = 1'b1;
                    count++;
                    stuck = 1'b0;
                    safe_seq_q.push_back(t_seq_entry'{pid: 3'(p), safe: 1'b1,
                                                      last: (count == np)});
                end
            end
            // a pass that finishes nobody closes the run as unsafe
            if (stuck) safe_seq_q.push_back(t_seq_entry'{pid: '0, safe: 1'b0, last: 1'b1});
        end
    endtask

    task automatic apply_command(input t_cmd cmd, input logic [PIDX_BITS-1:0] pidx,
                                 input logic [RIDX_BITS-1:0] ridx,
                                 input logic [AMT_IN_BITS-1:0] amt);
        case (cmd)
            CMD_LOAD_AVAIL: avail_mem[ridx]       = amt;
            CMD_LOAD_CLAIM: claim_mem[pidx][ridx] = amt;
            CMD_LOAD_ALLOC: alloc_mem[pidx][ridx] = amt;
            CMD_RUN:        run_safety_check();
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_seq_entry want;
        if (!i_rst_n) begin
            proc_cnt = PROC_CFG_RESET;
            res_cnt  = RES_CFG_RESET;
            safe_seq_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROCESSES: proc_cnt = i_cfg_data[PROC_CFG_BITS-1:0];
                    CFG_RESOURCES: res_cnt  = i_cfg_data[RES_CFG_BITS-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(t_cmd'(s_axis_tuser),
                              s_axis_tdata[LD_PIDX_LSB +: PIDX_BITS],
                              s_axis_tdata[LD_RIDX_LSB +: RIDX_BITS],
                              s_axis_tdata[LD_AMT_LSB +: AMT_IN_BITS]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (safe_seq_q.size() == 0) begin
                    $error("unexpected result transfer: process_id %0d safe %0d last %0d",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = safe_seq_q.pop_front();
                    if (m_axis_tdata !== M_TDATA_BITS'(want.pid)) begin
                        $error("process_id: expected %0d, got %0d", want.pid, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.safe) begin
                        $error("safe: expected %0d, got %0d", want.safe, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= safe_seq_q.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the banker's safety check
// Loads available, claim and allocation elements and issues run commands over
// a series of process/resource settings, with random gaps on the load side,
// random and long stalls on the result side; the checker scores each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 700;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic [CMD_BITS-1:0]      s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_idx                 i_cfg_index = CFG_PROCESSES;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int mismatches;
    int pending;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_req     = 1'b0;
    bit hold_taken   = 1'b0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int sent_count   = 0;

    // which store entries hold a loaded value
    bit avail_set [4];
    bit claim_set [8][4];
    bit alloc_set [8][4];

    bankers_safety_check u_top (.*);

    bsc_checker u_chk (
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .*
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp_cnt(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] pick_amount();
        int k;
        k = $urandom_range(99);
        if (k < 15) return $urandom_range(1) ? 8'hFF : 8'h00;
        if (k < 70) return 8'($urandom_range(15));
        return 8'($urandom_range(255));
    endfunction

    // valid stays up from one transfer to the next unless a gap is drawn
    task automatic send_item(input t_cmd cmd, input logic [2:0] pidx, input logic [1:0] ridx,
                             input logic [7:0] amt);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, amt, ridx, pidx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (cmd)
            CMD_LOAD_AVAIL: avail_set[ridx]       = 1'b1;
            CMD_LOAD_CLAIM: claim_set[pidx][ridx] = 1'b1;
            CMD_LOAD_ALLOC: alloc_set[pidx][ridx] = 1'b1;
            CMD_RUN:        ;
        endcase
        sent_count++;
    endtask

    task automatic write_config(input logic [3:0] procs, input logic [3:0] ress);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PROCESSES;
        i_cfg_data  <= procs;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_RESOURCES;
        i_cfg_data  <= ress;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic random_load(input int np, input int nr);
        t_cmd       cmd;
        logic [2:0] p;
        logic [1:0] r;
        cmd = t_cmd'($urandom_range(2));
        if ($urandom_range(9) < 8) begin
            p = 3'($urandom_range(np - 1));
            r = 2'($urandom_range(nr - 1));
        end else begin
            p = 3'($urandom_range(7));
            r = 2'($urandom_range(3));
        end
        if (cmd == CMD_LOAD_AVAIL)
            send_item(cmd, p, r, $urandom_range(1) ? pick_amount() : 8'($urandom_range(40)));
        else
            send_item(cmd, p, r, pick_amount());
    endtask

    // a run must only touch entries that were loaded before
    task automatic fill_unwritten(input int np, input int nr);
        for (int r = 0; r < nr; r++)
            if (!avail_set[r])
                send_item(CMD_LOAD_AVAIL, 3'($urandom), 2'(r), 8'($urandom_range(31)));
        for (int p = 0; p < np; p++) begin
            for (int r = 0; r < nr; r++) begin
                if (!claim_set[p][r]) send_item(CMD_LOAD_CLAIM, 3'(p), 2'(r), pick_amount());
                if (!alloc_set[p][r]) send_item(CMD_LOAD_ALLOC, 3'(p), 2'(r), pick_amount());
            end
        end
    endtask

    task automatic run_phase(input int procs, input int ress, input int snd_pct,
                             input int rcv_pct, input int budget, input bit squeeze);
        int np;
        int nr;
        int start;
        wait_idle(SETTLE_CYCLES);
        write_config(4'(procs), 4'(ress));
        snd_idle_pct = snd_pct;
        rcv_idle_pct <= rcv_pct;
        if (squeeze) hold_req <= 1'b1;
        np    = clamp_cnt(procs, 8);
        nr    = clamp_cnt(ress & 7, 4);
        start = sent_count;
        while (sent_count - start < budget) begin
            repeat ($urandom_range(1, 5)) random_load(np, nr);
            fill_unwritten(np, nr);
            send_item(CMD_RUN, 3'($urandom), 2'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two processes, two resources: p1 goes first, then p0
        write_config(4'd2, 4'd2);
        send_item(CMD_LOAD_AVAIL, 3'd0, 2'd0, 8'd1);
        send_item(CMD_LOAD_AVAIL, 3'd5, 2'd1, 8'd0);
        send_item(CMD_LOAD_CLAIM, 3'd0, 2'd0, 8'd3);
        send_item(CMD_LOAD_CLAIM, 3'd0, 2'd1, 8'd0);
        send_item(CMD_LOAD_ALLOC, 3'd0, 2'd0, 8'd1);
        send_item(CMD_LOAD_ALLOC, 3'd0, 2'd1, 8'd0);
        // claim below allocation, need clamps to zero
        send_item(CMD_LOAD_CLAIM, 3'd1, 2'd0, 8'd1);
        send_item(CMD_LOAD_CLAIM, 3'd1, 2'd1, 8'd255);
        send_item(CMD_LOAD_ALLOC, 3'd1, 2'd0, 8'd5);
        send_item(CMD_LOAD_ALLOC, 3'd1, 2'd1, 8'd255);
        send_item(CMD_RUN, 3'd0, 2'd0, 8'd0);
        // top corners of the stores, outside the active area
        send_item(CMD_LOAD_AVAIL, 3'd7, 2'd3, 8'd255);
        send_item(CMD_LOAD_CLAIM, 3'd7, 2'd3, 8'd255);
        send_item(CMD_LOAD_ALLOC, 3'd7, 2'd3, 8'd0);
        // nobody fits: unsafe right away
        send_item(CMD_LOAD_CLAIM, 3'd1, 2'd0, 8'd200);
        send_item(CMD_RUN, 3'd7, 2'd3, 8'd255);
        // p0 fits, p1 never does: one safe entry, then unsafe
        send_item(CMD_LOAD_AVAIL, 3'd2, 2'd0, 8'd2);
        send_item(CMD_RUN, 3'd3, 2'd2, 8'd170);
        // both fit within the first pass
        send_item(CMD_LOAD_CLAIM, 3'd1, 2'd0, 8'd0);
        send_item(CMD_RUN, 3'd4, 2'd1, 8'd85);

        run_phase(8,  4, 0,  0,  60, 1'b0);
        run_phase(5,  3, 45, 0,  10, 1'b0);
        run_phase(1,  1, 0,  45, 10, 1'b0);
        run_phase(15, 0, 24, 24, 10, 1'b0);
        run_phase(0,  7, 45, 0,  10, 1'b0);
        run_phase(8,  4, 0,  45, 10, 1'b1);
        run_phase(3,  2, 24, 24, 10, 1'b0);
        run_phase(6,  4, 0,  0,  10, 1'b0);

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/bsc_pkg.sv
rtl/bsc_ctrl.sv
rtl/bsc_dp.sv
rtl/bankers_safety_check.sv
tb/bsc_checker.sv
tb/tb.sv
